>>> hw/rtl/pfa_pkg.sv
// pfa_pkg: shared types, codes and reset table for the partition fit allocator
// no dependencies; imported by partition_fit_allocator and its testbench

package pfa_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int SIZE_BITS     = 16;
  localparam int TAG_BITS      = 8;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
  localparam int CFG_BITS      = 5;
  localparam int RESET_USE     = 10;

  // operation codes
  localparam logic OP_ALLOCATE = 1'b0;
  localparam logic OP_WRITE    = 1'b1;

  // policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_WRITTEN   = 2'd2;

  // one partition table entry
  typedef struct packed {
    logic                 taken;
    logic [TAG_BITS-1:0]  owner;
    logic [SIZE_BITS-1:0] size;
  } entry_t;

  // partition table contents after reset
  function automatic entry_t reset_entry(input logic [IDX_BITS-1:0] idx);
    entry_t e;
    e.owner = '0;
    e.taken = 1'b0;
    e.size  = '0;
    case (idx)
      IDX_BITS'(0): begin e.size = SIZE_BITS'(100); e.taken = 1'b1; end
      IDX_BITS'(1): begin e.size = SIZE_BITS'(500); end
      IDX_BITS'(2): begin e.size = SIZE_BITS'(200); e.taken = 1'b1; end
      IDX_BITS'(3): begin e.size = SIZE_BITS'(300); end
      IDX_BITS'(4): begin e.size = SIZE_BITS'(600); end
      IDX_BITS'(5): begin e.size = SIZE_BITS'(150); e.taken = 1'b1; end
      IDX_BITS'(6): begin e.size = SIZE_BITS'(250); end
      IDX_BITS'(7): begin e.size = SIZE_BITS'(400); end
      IDX_BITS'(8): begin e.size = SIZE_BITS'(350); e.taken = 1'b1; end
      IDX_BITS'(9): begin e.size = SIZE_BITS'(700); end
      default: begin e.size = '0; end
    endcase
    return e;
  endfunction

endpackage

>>> hw/rtl/partition_fit_allocator.sv
// partition_fit_allocator: fixed partition table with first, best, worst and next fit
// depends on pfa_pkg (types, codes, reset table)
//
// usage:
//   input channel (in_valid / in_stall) carries one request item: an allocate
//   with a policy and a size, or a write of one table entry. output channel
//   (out_valid / out_stall) returns one result item per request.
//   cfg_write / cfg_data set partitions_in_use; write it only while idle.
// sequencing:
//   one request at a time. a write, or an allocate with no partitions in use,
//   goes straight to the done state on accept. any other allocate first
//   reduces its start index (the rover for next fit, else zero) modulo the
//   live entry count (partitions_in_use, capped at 16) by repeated subtract,
//   then reads the table memory one entry a cycle through a registered read.
//   the chosen entry is written back on the cycle the result is loaded, and
//   the next item is accepted on the cycle after that.
// reset:
//   rst is synchronous, active high. the table reads as its ten preset
//   partitions through per-entry valid bits, no clearing pass; the rover is
//   cleared and partitions_in_use returns to 10.
// stall:
//   the result sits in the output register while out_stall is high; a
//   finished request waits there and in_stall stays high until it can load.

module partition_fit_allocator (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [pfa_pkg::CFG_BITS-1:0]  cfg_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [1:0]                    policy,
  input  logic [pfa_pkg::SIZE_BITS-1:0] request_size,
  input  logic [pfa_pkg::TAG_BITS-1:0]  owner_tag,
  input  logic [pfa_pkg::IDX_BITS-1:0]  entry_index,
  input  logic [pfa_pkg::SIZE_BITS-1:0] entry_size,
  input  logic                          entry_taken,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [pfa_pkg::IDX_BITS-1:0]  granted_index,
  output logic [pfa_pkg::SIZE_BITS-1:0] granted_size
);
  import pfa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state;
  logic [CFG_BITS-1:0]  partitions_in_use;
  logic [IDX_BITS-1:0]  rover;

  // latched request
  logic                 req_op;
  logic [1:0]           req_policy;
  logic [SIZE_BITS-1:0] req_need;
  logic [TAG_BITS-1:0]  req_tag;
  logic [IDX_BITS-1:0]  req_widx;
  logic [SIZE_BITS-1:0] req_wsize;
  logic                 req_wtaken;

  // scan control
  logic [CFG_BITS-1:0]  rem;
  logic [IDX_BITS-1:0]  rd_addr;
  logic                 scan_issue;
  logic [CNT_BITS-1:0]  issued;
  logic                 eval_live;
  logic [IDX_BITS-1:0]  eval_idx;
  logic                 found;
  logic [IDX_BITS-1:0]  pick;
  logic [SIZE_BITS-1:0] pick_size;

  // table memory and valid bits
  entry_t               mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] written;
  entry_t               rd_word;
  logic                 rd_written;
  logic                 mem_we;
  logic [IDX_BITS-1:0]  mem_waddr;
  entry_t               mem_wdata;

  logic                 accept;
  logic                 done_load;
  logic [CNT_BITS-1:0]  count;
  entry_t               cur;
  logic                 cur_fits;
  logic                 take;
  logic [CNT_BITS-1:0]  addr_inc;
  logic [CNT_BITS-1:0]  pick_inc;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign done_load = (state == S_DONE) && (!out_valid || !out_stall);

  // live entry count, saturated to table depth
  always_comb begin
    if (partitions_in_use > CFG_BITS'(TABLE_ENTRIES)) begin
      count = CNT_BITS'(TABLE_ENTRIES);
    end else begin
      count = CNT_BITS'(partitions_in_use);
    end
  end

  // entry under evaluation: never written entries read as reset contents
  assign cur      = rd_written ? rd_word : reset_entry(eval_idx);
  assign cur_fits = !cur.taken && (cur.size >= req_need);

  always_comb begin
    take = 1'b0;
    if (eval_live && cur_fits) begin
      case (req_policy)
        POL_BEST:  take = !found || (cur.size < pick_size);
        POL_WORST: take = !found || (cur.size > pick_size);
        default:   take = !found;
      endcase
    end
  end

  // circular address step over the live entries
  assign addr_inc = CNT_BITS'(rd_addr) + CNT_BITS'(1);
  assign pick_inc = CNT_BITS'(pick) + CNT_BITS'(1);

  // write-back of the result
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req_widx;
    mem_wdata = '{taken: req_wtaken, owner: req_tag, size: req_wsize};
    if (done_load) begin
      if (req_op == OP_WRITE) begin
        mem_we = 1'b1;
      end else if (found) begin
        mem_we    = 1'b1;
        mem_waddr = pick;
        mem_wdata = '{taken: 1'b1, owner: req_tag, size: pick_size};
      end
    end
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_word <= mem[rd_addr];
  end

  // valid bits and read pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
      eval_live  <= 1'b0;
    end else begin
      if (mem_we) begin
        written[mem_waddr] <= 1'b1;
      end
      rd_written <= written[rd_addr];
      eval_live  <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx <= rd_addr;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      partitions_in_use <= CFG_BITS'(RESET_USE);
    end else if (cfg_write) begin
      partitions_in_use <= cfg_data;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op     <= operation;
      req_policy <= policy;
      req_need   <= request_size;
      req_tag    <= owner_tag;
      req_widx   <= entry_index;
      req_wsize  <= entry_size;
      req_wtaken <= entry_taken;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rover      <= '0;
      scan_issue <= 1'b0;
      issued     <= '0;
      found      <= 1'b0;
      rem        <= '0;
      rd_addr    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            found <= 1'b0;
            if (operation == OP_WRITE || count == '0) begin
              state <= S_DONE;
            end else if (policy == POL_NEXT) begin
              rem   <= CFG_BITS'(rover);
              state <= S_MOD;
            end else begin
              rem   <= '0;
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (rem >= CFG_BITS'(count)) begin
            rem <= rem - CFG_BITS'(count);
          end else begin
            rd_addr    <= rem[IDX_BITS-1:0];
            scan_issue <= 1'b1;
            issued     <= CNT_BITS'(1);
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            if (issued == count) begin
              scan_issue <= 1'b0;
            end else begin
              issued <= issued + CNT_BITS'(1);
              if (addr_inc == count) begin
                rd_addr <= '0;
              end else begin
                rd_addr <= addr_inc[IDX_BITS-1:0];
              end
            end
          end
          if (take) begin
            found <= 1'b1;
          end
          if (!scan_issue && !eval_live) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_load) begin
            if (req_op == OP_ALLOCATE && found && req_policy == POL_NEXT) begin
              if (pick_inc == count) begin
                rover <= '0;
              end else begin
                rover <= pick_inc[IDX_BITS-1:0];
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // best candidate so far
  always_ff @(posedge clk) begin
    if (take) begin
      pick      <= eval_idx;
      pick_size <= cur.size;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      if (req_op == OP_WRITE) begin
        status        <= ST_WRITTEN;
        granted_index <= '0;
        granted_size  <= '0;
      end else if (found) begin
        status        <= ST_ALLOCATED;
        granted_index <= pick;
        granted_size  <= pick_size;
      end else begin
        status        <= ST_NO_FIT;
        granted_index <= '0;
        granted_size  <= '0;
      end
    end
  end

  // an accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("request channel not stalled after accepting an item");

  // reads issued never run past the live entry count
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issued <= count))
    else $error("scan issued more reads than live entries");

  // evaluation only follows an issued read
  a_eval_follows_issue: assert property (@(posedge clk) disable iff (rst)
    eval_live |-> $past(scan_issue))
    else $error("entry evaluated without a read issued");

  // no-fit and write results carry zero index and size
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_NO_FIT || status == ST_WRITTEN))
      |-> (granted_index == '0 && granted_size == '0))
    else $error("non-grant result carries a nonzero index or size");

endmodule

>>> tb/partition_fit_allocator_test.sv
// partition_fit_allocator_test: self-checking testbench for the partition fit allocator
// drives request items, predicts every grant from its own table copy, checks each result
// depends on pfa_pkg and partition_fit_allocator

`timescale 1ns / 100ps

module partition_fit_allocator_test;
  import pfa_pkg::*;

  typedef struct {
    logic                 op;
    logic [1:0]           pol;
    logic [SIZE_BITS-1:0] need;
    logic [TAG_BITS-1:0]  tag;
    logic [IDX_BITS-1:0]  widx;
    logic [SIZE_BITS-1:0] wsize;
    logic                 wtaken;
  } request_t;

  typedef struct {
    logic [1:0]           status;
    logic [IDX_BITS-1:0]  index;
    logic [SIZE_BITS-1:0] size;
  } grant_t;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [CFG_BITS-1:0]  cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic                 operation    = OP_ALLOCATE;
  logic [1:0]           policy       = POL_FIRST;
  logic [SIZE_BITS-1:0] request_size = '0;
  logic [TAG_BITS-1:0]  owner_tag    = '0;
  logic [IDX_BITS-1:0]  entry_index  = '0;
  logic [SIZE_BITS-1:0] entry_size   = '0;
  logic                 entry_taken  = 1'b0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [1:0]           status;
  logic [IDX_BITS-1:0]  granted_index;
  logic [SIZE_BITS-1:0] granted_size;

  partition_fit_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .policy        (policy),
    .request_size  (request_size),
    .owner_tag     (owner_tag),
    .entry_index   (entry_index),
    .entry_size    (entry_size),
    .entry_taken   (entry_taken),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .granted_index (granted_index),
    .granted_size  (granted_size)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // shadow partition table and rover
  logic [SIZE_BITS-1:0] part_size  [TABLE_ENTRIES];
  logic                 part_taken [TABLE_ENTRIES];
  logic [TAG_BITS-1:0]  part_owner [TABLE_ENTRIES];
  logic [IDX_BITS-1:0]  rover;
  logic [CFG_BITS-1:0]  partitions_live = CFG_BITS'(RESET_USE);

  request_t request_queue[$];
  grant_t   pending_grants[$];
  request_t current_request;
  int       mismatch_count = 0;
  int       in_gap_left    = 0;
  int       in_quiet       = 0;
  int       out_wait_left  = 0;
  int       out_quiet      = 0;

  initial begin
    int       k;
    int       sizes [10];
    bit       flags [10];
    sizes = '{100, 500, 200, 300, 600, 150, 250, 400, 350, 700};
    flags = '{1, 0, 1, 0, 0, 1, 0, 0, 1, 0};
    for (k = 0; k < TABLE_ENTRIES; k++) begin
      part_size[k]  = (k < 10) ? SIZE_BITS'(sizes[k]) : '0;
      part_taken[k] = (k < 10) ? flags[k] : 1'b0;
      part_owner[k] = '0;
    end
    rover = '0;
  end

  // free and large enough
  function automatic bit entry_fits(input int i, input logic [SIZE_BITS-1:0] need);
    return !part_taken[i] && part_size[i] >= need;
  endfunction

  // work out the grant for one request and update the shadow table
  function automatic grant_t grant_partition(input request_t r);
    grant_t g;
    int     count;
    int     start;
    int     k;
    int     i;
    int     pick;
    bit     found;
    g.status = ST_NO_FIT;
    g.index  = '0;
    g.size   = '0;
    found    = 1'b0;
    pick     = 0;
    count    = (partitions_live > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(partitions_live);
    if (r.op == OP_WRITE) begin
      part_size[r.widx]  = r.wsize;
      part_taken[r.widx] = r.wtaken;
      part_owner[r.widx] = r.tag;
      g.status = ST_WRITTEN;
      return g;
    end
    if (r.pol == POL_NEXT) begin
      // circular scan from the rover
      if (count > 0) begin
        start = int'(rover) % count;
        for (k = 0; k < count; k++) begin
          i = (start + k) % count;
          if (!found && entry_fits(i, r.need)) begin
            found = 1'b1;
            pick  = i;
          end
        end
        if (found) rover = IDX_BITS'((pick + 1) % count);
      end
    end else begin
      // linear scan, ties stay with the lower index
      for (i = 0; i < count; i++) begin
        if (entry_fits(i, r.need)) begin
          if (!found) begin
            found = 1'b1;
            pick  = i;
          end else if (r.pol == POL_BEST && part_size[i] < part_size[pick]) begin
            pick = i;
          end else if (r.pol == POL_WORST && part_size[i] > part_size[pick]) begin
            pick = i;
          end
        end
      end
    end
    if (found) begin
      part_taken[pick] = 1'b1;
      part_owner[pick] = r.tag;
      g.status = ST_ALLOCATED;
      g.index  = IDX_BITS'(pick);
      g.size   = part_size[pick];
    end
    return g;
  endfunction

  // idle cycles before the next item, with occasional runs of none
  function automatic int draw_idle(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [SIZE_BITS-1:0] draw_size();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return '0;
      1: return '1;
      2: return SIZE_BITS'($urandom);
      3, 4, 5: return SIZE_BITS'($urandom_range(0, 10) * 100);
      default: return SIZE_BITS'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
  endtask

  task automatic push_allocate(input logic [1:0] pol, input logic [SIZE_BITS-1:0] need,
                               input logic [TAG_BITS-1:0] tag);
    request_t r;
    r.op     = OP_ALLOCATE;
    r.pol    = pol;
    r.need   = need;
    r.tag    = tag;
    r.widx   = IDX_BITS'($urandom);
    r.wsize  = SIZE_BITS'($urandom);
    r.wtaken = 1'($urandom);
    request_queue.push_back(r);
  endtask

  task automatic push_write(input logic [IDX_BITS-1:0] idx, input logic [SIZE_BITS-1:0] size,
                            input logic taken, input logic [TAG_BITS-1:0] tag);
    request_t r;
    r.op     = OP_WRITE;
    r.pol    = 2'($urandom);
    r.need   = SIZE_BITS'($urandom);
    r.tag    = tag;
    r.widx   = idx;
    r.wsize  = size;
    r.wtaken = taken;
    request_queue.push_back(r);
  endtask

  // wait until every item is sent and every grant has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (request_queue.size() != 0 || in_valid || pending_grants.size() != 0);
    repeat (24) @(posedge clk);
  endtask

  task automatic set_partitions_in_use(input logic [CFG_BITS-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    partitions_live = value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_grants.push_back(grant_partition(current_request));
        in_gap_left = draw_idle(in_quiet);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          current_request = request_queue.pop_front();
          operation    <= current_request.op;
          policy       <= current_request.pol;
          request_size <= current_request.need;
          owner_tag    <= current_request.tag;
          entry_index  <= current_request.widx;
          entry_size   <= current_request.wsize;
          entry_taken  <= current_request.wtaken;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_grants.size() == 0) begin
          report_mismatch("unexpected result status", status, 0);
        end else begin
          want = pending_grants.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (granted_index !== want.index)
            report_mismatch("granted_index", granted_index, want.index);
          if (granted_size !== want.size)
            report_mismatch("granted_size", granted_size, want.size);
        end
        out_wait_left = draw_idle(out_quiet);
      end else if (out_valid && out_wait_left > 0) begin
        out_wait_left--;
      end
      out_stall <= (out_wait_left > 0);
    end
  end

  // stimulus
  initial begin
    int n;
    int p;
    int cfg_plan [10];
    cfg_plan = '{16, 1, 10, 31, 0, 2, 16, 17, 7, 16};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: each policy on the reset table, then no fit on every policy
    push_allocate(POL_FIRST, 16'd0, 8'h00);
    push_allocate(POL_BEST, 16'd250, 8'hff);
    push_allocate(POL_WORST, 16'd1, 8'h5a);
    push_allocate(POL_NEXT, 16'd300, 8'ha5);
    push_allocate(POL_NEXT, 16'd0, 8'h01);
    push_allocate(POL_FIRST, 16'hffff, 8'h02);
    push_allocate(POL_BEST, 16'hffff, 8'h03);
    push_allocate(POL_WORST, 16'hffff, 8'h04);
    push_allocate(POL_NEXT, 16'hffff, 8'h05);
    // writes at the index and size extremes; zero size entry fits a zero request
    push_write(4'd15, 16'hffff, 1'b0, 8'hff);
    push_write(4'd0, 16'd0, 1'b0, 8'h00);
    push_allocate(POL_FIRST, 16'd0, 8'h10);
    // ties for best and worst fit
    push_write(4'd3, 16'd500, 1'b0, 8'h11);
    push_write(4'd7, 16'd500, 1'b0, 8'h12);
    push_allocate(POL_BEST, 16'd450, 8'h13);
    push_write(4'd4, 16'd700, 1'b0, 8'h14);
    push_write(4'd9, 16'd700, 1'b1, 8'h15);
    push_write(4'd9, 16'd700, 1'b0, 8'h16);
    push_allocate(POL_WORST, 16'd1, 8'h17);

    // full table: the largest entry sits at the top index
    set_partitions_in_use(5'd16);
    push_allocate(POL_WORST, 16'hffff, 8'h20);
    push_write(4'd14, 16'd1, 1'b0, 8'h21);
    push_allocate(POL_NEXT, 16'd1, 8'h22);

    // nothing in use: every allocation misses
    set_partitions_in_use(5'd0);
    push_allocate(POL_FIRST, 16'd0, 8'h30);
    push_allocate(POL_NEXT, 16'd0, 8'h31);

    // above table depth saturates
    set_partitions_in_use(5'd31);
    push_allocate(POL_WORST, 16'd0, 8'h40);

    // rover left beyond a shrunk table
    set_partitions_in_use(5'd3);
    push_write(4'd1, 16'd50, 1'b0, 8'h41);
    push_allocate(POL_NEXT, 16'd10, 8'h42);

    // random phases over a range of table sizes
    for (p = 0; p < 10; p++) begin
      set_partitions_in_use(CFG_BITS'(cfg_plan[p]));
      for (n = 0; n < 105; n++) begin
        if ($urandom_range(0, 99) < 35)
          push_write(IDX_BITS'($urandom_range(0, 15)), draw_size(),
                     ($urandom_range(0, 3) == 0), TAG_BITS'($urandom_range(0, 255)));
        else
          push_allocate(2'($urandom_range(0, 3)), draw_size(),
                        TAG_BITS'($urandom_range(0, 255)));
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
